// ===== rtl/slpg_pkg.sv =====
// package with types, constants and pattern function of the status led pattern generator
`timescale 1ns / 1ps
package slpg_pkg;

  localparam int unsigned MODE_W        = 3;
  localparam int unsigned INTRO_W       = 10;
  localparam int unsigned PHASE_W       = 11;
  localparam int unsigned SINCE_W       = 8;
  localparam int unsigned PERIOD_W      = 8;
  localparam int unsigned CFG_INDEX_W   = 1;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam int unsigned INTRO_END     = 900;
  localparam int unsigned PHASE_WRAP    = 2000;
  localparam int unsigned BLINK_PERIOD  = 1000;
  localparam int unsigned BLINK_ON      = 500;
  localparam int unsigned INTRO_SHIFT   = 100;
  localparam int unsigned FLASH_LEN     = 120;
  localparam int unsigned FLASH2_START  = 300;
  localparam int unsigned FLASH3_START  = 600;
  localparam int unsigned SINCE_MAX     = 255;
  localparam int unsigned REFRESH_RESET = 20;

  typedef enum logic [MODE_W-1:0] {
    MODE_BOOTING    = 3'd0,
    MODE_NO_CONFIG  = 3'd1,
    MODE_SETUP      = 3'd2,
    MODE_CONNECTING = 3'd3,
    MODE_CONNECTED  = 3'd4,
    MODE_ERROR      = 3'd5
  } mode_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_MODE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_LOW     = 1'b0,
    REG_REFRESH_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                command;
    logic [MODE_W-1:0]   new_mode;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic                active_low;
    logic [PERIOD_W-1:0] refresh_period;
  } cfg_t;

  function automatic logic in_flashes(logic [PHASE_W-1:0] p, logic three);
    logic lit;
    lit = (p < PHASE_W'(FLASH_LEN))
        || (p >= PHASE_W'(FLASH2_START) && p < PHASE_W'(FLASH2_START + FLASH_LEN))
        || (three && p >= PHASE_W'(FLASH3_START)
            && p < PHASE_W'(FLASH3_START + FLASH_LEN));
    return lit;
  endfunction

  function automatic logic pattern_value(logic [MODE_W-1:0] m, logic [INTRO_W-1:0] intro,
                                         logic [PHASE_W-1:0] p);
    logic lit;
    lit = 1'b0;
    case (m)
      MODE_BOOTING: lit = 1'b1;
      MODE_NO_CONFIG: begin
        if (intro < INTRO_W'(INTRO_END)) begin
          lit = in_flashes(PHASE_W'(intro), 1'b1);
        end else begin
          // (p + shift) mod period below on-time, unrolled over the wrap range
          lit = (p < PHASE_W'(BLINK_ON - INTRO_SHIFT))
              || (p >= PHASE_W'(BLINK_PERIOD - INTRO_SHIFT)
                  && p < PHASE_W'(BLINK_PERIOD + BLINK_ON - INTRO_SHIFT))
              || (p >= PHASE_W'(PHASE_WRAP - INTRO_SHIFT));
        end
      end
      MODE_SETUP: begin
        lit = (p < PHASE_W'(BLINK_ON))
            || (p >= PHASE_W'(BLINK_PERIOD) && p < PHASE_W'(BLINK_PERIOD + BLINK_ON));
      end
      MODE_CONNECTING: lit = in_flashes(p, 1'b0);
      MODE_CONNECTED:  lit = 1'b0;
      MODE_ERROR:      lit = in_flashes(p, 1'b1);
      default:         lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

// ===== rtl/slpg_if.sv =====
// channel interfaces for items, results and configuration writes
`timescale 1ns / 1ps
interface slpg_item_if import slpg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [MODE_W-1:0] new_mode;
  modport source (output valid, command, new_mode, input ready);
  modport sink   (input valid, command, new_mode, output ready);
endinterface

interface slpg_result_if;
  logic valid;
  logic ready;
  logic led_on;
  logic pin_level;
  modport source (output valid, led_on, pin_level, input ready);
  modport sink   (input valid, led_on, pin_level, output ready);
endinterface

interface slpg_cfg_if import slpg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/slpg_cfg_regs.sv =====
// configuration registers of the status led pattern generator
`timescale 1ns / 1ps
module slpg_cfg_regs import slpg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  slpg_cfg_if.sink cfg,
  output cfg_t     cfg_q
);

  logic                active_low;
  logic [PERIOD_W-1:0] refresh_period;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low     <= 1'b0;
      refresh_period <= PERIOD_W'(REFRESH_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_LOW:     active_low     <= cfg.data[0];
        REG_REFRESH_PERIOD: refresh_period <= cfg.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_q.active_low     = active_low;
  assign cfg_q.refresh_period = refresh_period;

endmodule

// ===== rtl/slpg_in_stage.sv =====
// input register that holds one item until the engine takes it
`timescale 1ns / 1ps
module slpg_in_stage import slpg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  slpg_item_if.sink item_in,
  input  logic      take,
  output stage_t    stage
);

  logic  valid;
  item_t item;

  assign item_in.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_in.ready) begin
      valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      item.command  <= item_in.command;
      item.new_mode <= item_in.new_mode;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ===== rtl/slpg_engine.sv =====
// mode timing state, led evaluation and result register
`timescale 1ns / 1ps
module slpg_engine import slpg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  stage_t        stage,
  input  cfg_t          cfg_q,
  output logic          take,
  slpg_result_if.source result_out
);

  logic [MODE_W-1:0]  mode, mode_next;
  logic [INTRO_W-1:0] intro_time, intro_time_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [SINCE_W-1:0] since_refresh, since_refresh_next;
  logic               led, led_next;
  logic               out_valid;
  logic               led_on;
  logic               pin_level;
  logic [SINCE_W-1:0] since_inc;

  assign take = stage.valid && (!out_valid || result_out.ready);

  always_comb begin
    mode_next          = mode;
    intro_time_next    = intro_time;
    phase_next         = phase;
    since_refresh_next = since_refresh;
    led_next           = led;
    since_inc          = (since_refresh < SINCE_W'(SINCE_MAX)) ? since_refresh + 1'b1
                                                               : since_refresh;
    case (stage.item.command)
      CMD_MODE: begin
        if (stage.item.new_mode <= MODE_ERROR && stage.item.new_mode != mode) begin
          mode_next          = stage.item.new_mode;
          intro_time_next    = '0;
          phase_next         = '0;
          since_refresh_next = '0;
          led_next           = pattern_value(stage.item.new_mode, '0, '0);
        end
      end
      default: begin
        if (intro_time < INTRO_W'(INTRO_END)) begin
          intro_time_next = intro_time + 1'b1;
        end
        phase_next = (phase == PHASE_W'(PHASE_WRAP - 1)) ? '0 : phase + 1'b1;
        since_refresh_next = since_inc;
        if (since_inc >= cfg_q.refresh_period) begin
          since_refresh_next = '0;
          led_next           = pattern_value(mode, intro_time_next, phase_next);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_BOOTING;
      intro_time    <= '0;
      phase         <= '0;
      since_refresh <= '0;
      led           <= 1'b1;
    end else if (take) begin
      mode          <= mode_next;
      intro_time    <= intro_time_next;
      phase         <= phase_next;
      since_refresh <= since_refresh_next;
      led           <= led_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      led_on    <= led_next;
      pin_level <= led_next ^ cfg_q.active_low;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.led_on    = led_on;
  assign result_out.pin_level = pin_level;

endmodule

// ===== rtl/status_led_pattern_generator_core.sv =====
// top level of the status led pattern generator
// Usage:
//   item_in carries one item per handshake: command 0 is a one-millisecond
//   tick, command 1 asks for mode new_mode (codes six and seven are ignored).
//   result_out returns exactly one item per input item: led_on and pin_level
//   (led_on xor active_low), in input order.
//   cfg writes register 0 (active_low) or 1 (refresh_period), always ready;
//   the user must write it only while no item is in flight (unchecked).
// Timing:
//   an item waits in the input register until the engine takes it, and its
//   result is then registered in the result register.
//   one item per cycle is taken as long as results are taken; the input
//   register and the result register each hold one item.
// Reset (rst, synchronous): mode booting, timing cleared, led lit,
//   active_low 0, refresh_period 20, both channels empty.
// Stall: while result_out.ready is low a held result stays; one more item is
//   taken into the input register, then item_in.ready drops.
`timescale 1ns / 1ps
module status_led_pattern_generator_core import slpg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  slpg_item_if.sink     item_in,
  slpg_result_if.source result_out,
  slpg_cfg_if.sink      cfg
);

  cfg_t   cfg_q;
  stage_t stage;
  logic   take;

  slpg_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  slpg_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .take    (take),
    .stage   (stage)
  );

  slpg_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .cfg_q      (cfg_q),
    .take       (take),
    .result_out (result_out)
  );

endmodule
